// ===== sv/edsg_pkg.sv =====
// Package: shared types and constants of the encoder delta spike gate.
package edsg_pkg;
    localparam int unsigned REACQ_GOOD = 3;
    localparam logic [6:0]  STREAK_MAX = 7'h7F;
    localparam logic [2:0]  REG_SCALE  = 3'd0;
    localparam logic [2:0]  REG_MAXSPD = 3'd1;
    localparam logic [2:0]  REG_SPIKE  = 3'd2;
    localparam logic [2:0]  REG_MINWIN = 3'd3;
    localparam logic [2:0]  REG_REJECT = 3'd4;
    localparam logic [2:0]  REG_TRACK  = 3'd5;

    // divider request / status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [95:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [95:0] quotient;
    } t_div_rsp;
endpackage

// ===== sv/encoder_delta_spike_gate_top.sv =====
// Top level: encoder delta speed gate with window, streak and reacquire logic.
// Each transaction passes prepare, multiply, a speed division, a spike division (both
// on one shared restoring divider), decide and output; the spike division is skipped
// when the spike check is skipped or the sample is already rejected. s_axis_tready is
// low until the result is posted, so no new transaction enters before then, later while the result side stalls.
// Reset (sync, active low) clears window, sums, streak, flag, tally; streak_tracking=1.
module encoder_delta_spike_gate_top #(
    parameter int WINDOW_SAMPLES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: count_delta[31:0], interval_ms[47:32]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: accepted[0], reacquire_active[1], streak_count[8:2],
    //        rebuilds_so_far[24:9], zero pad [31:25]
    output logic [31:0] m_axis_tdata
);
    import edsg_pkg::*;

    localparam int SW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int FW = $clog2(WINDOW_SAMPLES + 1);
    localparam int DTW = 32 + $clog2(WINDOW_SAMPLES) + 1;
    localparam int ITW = 16 + $clog2(WINDOW_SAMPLES) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_PREP = 3'd6;

    // configuration
    logic [31:0] r_scale, r_maxspd, r_spike;
    logic [7:0]  r_minwin;
    logic [6:0]  r_rejlim;
    logic        r_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0; r_maxspd <= '0; r_spike <= '0;
            r_minwin <= '0; r_rejlim <= '0; r_track <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SCALE:  r_scale  <= i_cfg_wdata;
                REG_MAXSPD: r_maxspd <= i_cfg_wdata;
                REG_SPIKE:  r_spike  <= i_cfg_wdata;
                REG_MINWIN: r_minwin <= i_cfg_wdata[7:0];
                REG_REJECT: r_rejlim <= i_cfg_wdata[6:0];
                REG_TRACK:  r_track  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // window storage
    logic signed [31:0] r_dh [WINDOW_SAMPLES];
    logic [15:0]        r_ih [WINDOW_SAMPLES];
    logic signed [DTW-1:0] r_dtot;
    logic [ITW-1:0]     r_itot;
    logic [SW-1:0]      r_slot;
    logic [FW-1:0]      r_fill;
    logic [6:0]         r_streak;
    logic               r_reacq;
    logic [15:0]        r_tally;

    logic [2:0]  r_st;
    logic signed [31:0] r_d;
    logic [15:0] r_dt;
    logic [63:0] r_cur;
    logic        r_cneg, r_hneg;
    logic [31:0] r_mag;      // |delta| of the current sample
    logic [DTW-1:0] r_hmag;
    logic        r_ok;
    logic [31:0] r_out;
    logic        r_ov;

    t_div_req w_req;
    t_div_rsp w_rsp;
    edsg_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // products registered before they feed the divider
    logic [63:0] r_pcur;
    logic [95:0] r_phist;
    always_ff @(posedge i_clk) begin
        r_pcur  <= {32'd0, r_mag} * {32'd0, r_scale};
        r_phist <= 96'({{(96-DTW){1'b0}}, r_hmag} * {64'd0, r_scale});
    end

    logic w_qsat;
    logic [63:0] w_q64;
    assign w_qsat = |w_rsp.quotient[95:64];
    assign w_q64  = w_qsat ? '1 : w_rsp.quotient[63:0];

    logic w_skip;
    assign w_skip = (r_spike == 32'd0) || ({{(9-FW){1'b0}}, r_fill} < {1'b0, r_minwin})
                    || (r_itot == '0);

    // spike decision
    logic [63:0] w_hist, w_diff;
    logic        w_cn, w_hn;
    logic [64:0] w_sum;
    always_comb begin
        w_hist = w_q64;
        w_cn   = r_cneg && (r_cur != 64'd0);
        w_hn   = r_hneg && (w_hist != 64'd0);
        w_sum  = {1'b0, r_cur} + {1'b0, w_hist};
        if (w_cn == w_hn) w_diff = (r_cur > w_hist) ? r_cur - w_hist : w_hist - r_cur;
        else              w_diff = w_sum[64] ? '1 : w_sum[63:0];
    end

    assign w_req.start    = (r_st == ST_MUL) ||
                            (r_st == ST_DIV1 && w_rsp.done && r_ok && !w_skip);
    assign w_req.dividend = (r_st == ST_MUL) ? {32'd0, r_pcur} : r_phist;
    assign w_req.divisor  = (r_st == ST_MUL) ? {16'd0, r_dt} : 32'(r_itot);

    logic w_acc_in;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    // final update
    logic signed [DTW-1:0] w_ndtot;
    logic [ITW-1:0] w_nitot;
    assign w_ndtot = r_dtot - DTW'(r_dh[r_slot]) + DTW'(r_d);
    assign w_nitot = r_itot - ITW'(r_ih[r_slot]) + ITW'(r_dt);

    always_ff @(posedge i_clk) begin
        logic acc, clr, push, ov;
        logic [6:0] s;
        acc = 1'b0; clr = 1'b0; push = 1'b0; s = r_streak; ov = r_ov;
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0;
            r_dtot <= '0; r_itot <= '0; r_slot <= '0; r_fill <= '0;
            r_streak <= '0; r_reacq <= 1'b0; r_tally <= '0;
            for (int k = 0; k < WINDOW_SAMPLES; k++) begin
                r_dh[k] <= '0; r_ih[k] <= '0;
            end
        end else begin
            // result transaction frees the output register
            if (m_axis_tvalid && m_axis_tready) ov = 1'b0;
            case (r_st)
                ST_IDLE: if (w_acc_in) begin
                    r_d    <= s_axis_tdata[31:0];
                    r_dt   <= s_axis_tdata[47:32];
                    r_cneg <= s_axis_tdata[31];
                    r_mag  <= s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0])
                                               : s_axis_tdata[31:0];
                    r_hneg <= r_dtot < 0;
                    r_hmag <= (r_dtot < 0) ? DTW'(-r_dtot) : DTW'(r_dtot);
                    r_st   <= ST_PREP;
                end
                ST_PREP: begin
                    // r_pcur picks up |delta| * scale at this edge
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_ok <= (r_dt != 16'd0) && (r_scale != 32'd0);
                    r_st <= ST_DIV1;
                end
                ST_DIV1: if (w_rsp.done) begin
                    r_cur <= w_q64;
                    if (r_ok && r_maxspd != 32'd0 && w_q64 > {32'd0, r_maxspd})
                        r_ok <= 1'b0;
                    if (r_ok && !(r_maxspd != 32'd0 && w_q64 > {32'd0, r_maxspd})
                        && !w_skip)
                        r_st <= ST_DIV2;
                    else
                        r_st <= ST_DEC;
                end
                ST_DIV2: if (w_rsp.done) begin
                    r_ok <= w_diff <= {32'd0, r_spike};
                    r_st <= ST_DEC;
                end
                ST_DEC: begin
                    if (r_ok) begin
                        push = 1'b1; acc = 1'b1;
                        if (r_track) begin
                            if (r_reacq) begin
                                if (32'(r_streak) + 1 < REACQ_GOOD) begin
                                    s = r_streak + 7'd1; acc = 1'b0;
                                end else begin
                                    r_tally <= r_tally + 16'd1;
                                    r_reacq <= 1'b0; s = '0;
                                end
                            end else s = '0;
                        end
                    end else if (r_track) begin
                        if (r_reacq) begin
                            clr = 1'b1; s = '0;
                        end else begin
                            if (s < STREAK_MAX) s = s + 7'd1;
                            if (r_rejlim != 7'd0 && s >= r_rejlim) begin
                                clr = 1'b1; r_reacq <= 1'b1; s = '0;
                            end
                        end
                    end
                    r_streak <= s;
                    if (clr) begin
                        r_dtot <= '0; r_itot <= '0; r_slot <= '0; r_fill <= '0;
                        for (int k = 0; k < WINDOW_SAMPLES; k++) begin
                            r_dh[k] <= '0; r_ih[k] <= '0;
                        end
                    end else if (push) begin
                        r_dh[r_slot] <= r_d; r_ih[r_slot] <= r_dt;
                        r_dtot <= w_ndtot; r_itot <= w_nitot;
                        r_slot <= (32'(r_slot) == WINDOW_SAMPLES - 1) ? '0
                                  : r_slot + SW'(1);
                        if (32'(r_fill) < WINDOW_SAMPLES) r_fill <= r_fill + FW'(1);
                    end
                    r_ok <= acc;
                    r_st <= ST_OUT;
                end
                ST_OUT: if (!r_ov || m_axis_tready) begin
                    r_out <= {7'd0, r_tally, r_streak, r_reacq, r_ok};
                    ov    = 1'b1;
                    r_st  <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
            r_ov <= ov;
        end
    end

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
endmodule

// ===== sv/edsg_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module edsg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  edsg_pkg::t_div_req i_req,
    output edsg_pkg::t_div_rsp o_rsp
);
    import edsg_pkg::*;

    logic [95:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [32:0] w_sh;

    always_comb begin
        w_sh    = {r_rem[31:0], r_quo[95]};
        w_trial = w_sh - {1'b0, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial;
                n_quo = {r_quo[94:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[94:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd95) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_dvs <= i_req.divisor;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== sv/edsg_checker.sv =====
// Port-level checker for the encoder delta spike gate, bound to the top level.
module edsg_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready during processing");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
        else $error("pad bits set");
    a_acc_reacq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[8:2] < 7'd3)
        else $error("reacquire count out of range");
endmodule

bind encoder_delta_spike_gate_top edsg_port_props u_chk (.*);
